FILE: hw/rtl/sobmag_pkg.sv
package sobmag_pkg;

	// Field widths
	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int LW_W    = 11;
	localparam int GRAD_W  = 11;
	localparam int SQ_W    = 20;
	localparam int SUM_W   = 21;
	localparam int ROOT_W  = 8;
	localparam int CFG_W   = 12;

	// Configuration register indexes
	localparam logic CFG_LINE_WIDTH   = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [LW_W-1:0]  LINE_WIDTH_RST   = 11'd640;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// Any sum of squares above this saturates the root at full scale
	localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// One gradient waiting for its root
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_WIN,
		F_GRAD,
		F_SQ,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_ITER,
		R_RND
	} root_state_t;

endpackage

FILE: hw/rtl/sobmag_front.sv
module sobmag_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sobmag_pkg::PIX_W-1:0]      pixel,
	input  logic [sobmag_pkg::LW_W-1:0]       line_width,
	input  logic [sobmag_pkg::ROW_W-1:0]      frame_height,
	output logic                              q_push,
	input  logic                              q_full,
	output sobmag_pkg::item_t                 q_item
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = (AW > sobmag_pkg::COL_W) ? AW : sobmag_pkg::COL_W;
	localparam int RW = sobmag_pkg::ROW_W;
	localparam int PW = sobmag_pkg::PIX_W;
	localparam int GW = sobmag_pkg::GRAD_W;
	localparam int SW = sobmag_pkg::SQ_W;

	sobmag_pkg::front_state_t state_q, state_d;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [31:0]    lw32, fh32, w_eff, h_eff;
	logic           last_col, last_row, interior, accept;
	logic [CW-1:0]  col_m1;

	logic [PW-1:0]  px_q;
	logic [AW-1:0]  addr_q;
	logic           emit_q;
	logic [RW-1:0]  orow_q;
	logic [sobmag_pkg::COL_W-1:0] ocol_q;
	logic           done_q;

	logic [PW-1:0]  upper_mem [MAX_WIDTH];
	logic [PW-1:0]  middle_mem [MAX_WIDTH];
	logic [PW-1:0]  up_rd_q, mid_rd_q;

	logic [PW-1:0]  win_q [3][3];

	logic [PW+1:0]  gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [GW-1:0] gx_q, gy_q;
	logic signed [2*GW-1:0] gx_sq, gy_sq;
	logic [SW-1:0]  sqx_q, sqy_q;

	// Clamp the configured geometry and classify the incoming pixel
	always_comb begin
		lw32 = 32'(line_width);
		fh32 = 32'(frame_height);
		if (lw32 < 32'd3)
			w_eff = 32'd3;
		else if (lw32 > 32'(MAX_WIDTH))
			w_eff = 32'(MAX_WIDTH);
		else
			w_eff = lw32;
		h_eff = (fh32 < 32'd3) ? 32'd3 : fh32;
		last_col = (32'(col_q) + 32'd1) >= w_eff;
		last_row = (32'(row_q) + 32'd1) >= h_eff;
		interior = (row_q >= RW'(2)) && (col_q >= CW'(2));
		col_m1   = col_q - CW'(1);
	end

	assign accept = push && !full;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sobmag_pkg::F_IDLE: if (accept) state_d = sobmag_pkg::F_WIN;
			sobmag_pkg::F_WIN:  state_d = emit_q ? sobmag_pkg::F_GRAD : sobmag_pkg::F_IDLE;
			sobmag_pkg::F_GRAD: state_d = sobmag_pkg::F_SQ;
			sobmag_pkg::F_SQ:   state_d = sobmag_pkg::F_PUSH;
			sobmag_pkg::F_PUSH: if (!q_full) state_d = sobmag_pkg::F_IDLE;
			default:            state_d = sobmag_pkg::F_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		full   = (state_q != sobmag_pkg::F_IDLE);
		q_push = (state_q == sobmag_pkg::F_PUSH) && !q_full;
	end

	// Advance state and the raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sobmag_pkg::F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Hold the accepted beat and its output tags
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= pixel;
			addr_q <= col_q[AW-1:0];
			emit_q <= interior;
			orow_q <= row_q - RW'(1);
			ocol_q <= col_m1[sobmag_pkg::COL_W-1:0];
			done_q <= last_col && last_row;
		end
	end

	// Line stores: read on accept, write back the shifted column in the next cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_q  <= upper_mem[col_q[AW-1:0]];
			mid_rd_q <= middle_mem[col_q[AW-1:0]];
		end
		if (state_q == sobmag_pkg::F_WIN) begin
			upper_mem[addr_q]  <= mid_rd_q;
			middle_mem[addr_q] <= px_q;
		end
	end

	// Shift the 3x3 window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (state_q == sobmag_pkg::F_WIN) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= px_q;
		end
	end

	// Sobel sums
	always_comb begin
		gx_pos = {2'b00, win_q[0][2]} + {1'b0, win_q[1][2], 1'b0} + {2'b00, win_q[2][2]};
		gx_neg = {2'b00, win_q[0][0]} + {1'b0, win_q[1][0], 1'b0} + {2'b00, win_q[2][0]};
		gy_pos = {2'b00, win_q[2][0]} + {1'b0, win_q[2][1], 1'b0} + {2'b00, win_q[2][2]};
		gy_neg = {2'b00, win_q[0][0]} + {1'b0, win_q[0][1], 1'b0} + {2'b00, win_q[0][2]};
		gx_sq  = gx_q * gx_q;
		gy_sq  = gy_q * gy_q;
	end

	// Register gradients, then their squares
	always_ff @(posedge clk) begin
		if (state_q == sobmag_pkg::F_GRAD) begin
			gx_q <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
			gy_q <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		end
		if (state_q == sobmag_pkg::F_SQ) begin
			sqx_q <= gx_sq[SW-1:0];
			sqy_q <= gy_sq[SW-1:0];
		end
	end

	assign q_item = '{
		sum:  {1'b0, sqx_q} + {1'b0, sqy_q},
		row:  orow_q,
		col:  ocol_q,
		done: done_q
	};

	a_push_interior: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> emit_q)
		else $error("front pushed a border pixel");

	a_accept_win: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == sobmag_pkg::F_WIN))
		else $error("accepted beat did not reach the window stage");

endmodule

FILE: hw/rtl/sobmag_queue.sv
module sobmag_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sobmag_pkg::item_t wr_item,
	input  logic              pop,
	output logic              empty,
	output sobmag_pkg::item_t rd_item
);

	localparam int DEPTH = sobmag_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	sobmag_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + NW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - NW'(1);
		end
	end

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/sobmag_root.sv
module sobmag_root (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  sobmag_pkg::item_t                 q_item,
	output logic                              empty,
	input  logic                              pop,
	output logic [sobmag_pkg::ROOT_W-1:0]     edge_res,
	output logic [sobmag_pkg::ROW_W-1:0]      out_row,
	output logic [sobmag_pkg::COL_W-1:0]      out_col,
	output logic                              frame_done
);

	localparam int RTW = sobmag_pkg::ROOT_W;
	localparam int SMW = sobmag_pkg::SUM_W;
	localparam int BW  = $clog2(RTW);

	sobmag_pkg::root_state_t state_q, state_d;

	sobmag_pkg::item_t item_q;
	logic [RTW-1:0]    r_q;
	logic [BW-1:0]     bit_q;
	logic [RTW-1:0]    trial;
	logic [2*RTW-1:0]  trial_sq;
	logic [2*RTW-1:0]  r_sq;
	logic [2*RTW:0]    r_sq_r;
	logic [RTW-1:0]    res;
	logic              out_valid_q;
	logic              slot_free, load_out;

	// One root bit per cycle, then the rounding step
	always_comb begin
		trial    = r_q | (RTW'(1) << bit_q);
		trial_sq = trial * trial;
		r_sq     = r_q * r_q;
		r_sq_r   = {1'b0, r_sq} + (2*RTW+1)'(r_q);
		if (item_q.sum > sobmag_pkg::SAT_LIMIT)
			res = '1;
		else if (item_q.sum > SMW'(r_sq_r))
			res = r_q + RTW'(1);
		else
			res = r_q;
	end

	assign slot_free = !out_valid_q || pop;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sobmag_pkg::R_IDLE: if (!q_empty) state_d = sobmag_pkg::R_ITER;
			sobmag_pkg::R_ITER: if (bit_q == '0) state_d = sobmag_pkg::R_RND;
			sobmag_pkg::R_RND:  if (slot_free) state_d = sobmag_pkg::R_IDLE;
			default:            state_d = sobmag_pkg::R_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		q_pop    = (state_q == sobmag_pkg::R_IDLE) && !q_empty;
		load_out = (state_q == sobmag_pkg::R_RND) && slot_free;
	end

	// Advance state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sobmag_pkg::R_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	// Take a beat from the queue and refine the root
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			r_q    <= '0;
			bit_q  <= BW'(RTW - 1);
		end else if (state_q == sobmag_pkg::R_ITER) begin
			if (SMW'(trial_sq) <= item_q.sum)
				r_q <= trial;
			bit_q <= bit_q - BW'(1);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			edge_res   <= res;
			out_row    <= item_q.row;
			out_col    <= item_q.col;
			frame_done <= item_q.done;
		end
	end

	assign empty = !out_valid_q;

	a_iter_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sobmag_pkg::R_ITER && bit_q != '0) |=> (state_q == sobmag_pkg::R_ITER))
		else $error("root iteration cut short");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("loaded result not shown");

	a_pop_src: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

FILE: hw/rtl/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a grayscale raster stream.
// Input channel: drive pixel and raise push; a beat is taken at a clock edge
// with push high and full low. Pixels arrive in raster order, line_width per
// row and frame_height rows per frame.
// Result channel: while empty is low, edge_res, out_row, out_col and
// frame_done show the oldest result; raise pop to take it. Only interior
// pixels produce a result; frame_done marks the last one of a frame.
// Configuration: cfg_we with cfg_idx selects line_width (0) or frame_height
// (1), written from cfg_data; write only while the block is idle.
// The front takes no new pixel until it is back in idle: an interior pixel
// passes its window, gradient, square and push states, a border pixel only
// the window state. The iterative root unit takes one pixel at a time and
// sets the sustained rate. A two-entry queue separates front and root unit.
// Reset clears the counters and the window, empties the queue and the output
// register, and loads line_width 640 and frame_height 480. The line stores
// start unknown and are filled by the first two rows.
// A stalled receiver holds the output register; the queue then fills and
// full stays high until pop drains it.
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [sobmag_pkg::PIX_W-1:0]      pixel,
	output logic                              empty,
	input  logic                              pop,
	output logic [sobmag_pkg::ROOT_W-1:0]     edge_res,
	output logic [sobmag_pkg::ROW_W-1:0]      out_row,
	output logic [sobmag_pkg::COL_W-1:0]      out_col,
	output logic                              frame_done,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [sobmag_pkg::CFG_W-1:0]      cfg_data
);

	logic [sobmag_pkg::LW_W-1:0]  line_width_q;
	logic [sobmag_pkg::ROW_W-1:0] frame_height_q;

	logic              q_push, q_full, q_pop, q_empty;
	sobmag_pkg::item_t q_wr_item, q_rd_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= sobmag_pkg::LINE_WIDTH_RST;
			frame_height_q <= sobmag_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sobmag_pkg::CFG_LINE_WIDTH:   line_width_q <= cfg_data[sobmag_pkg::LW_W-1:0];
				sobmag_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[sobmag_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	sobmag_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel        (pixel),
		.line_width   (line_width_q),
		.frame_height (frame_height_q),
		.q_push       (q_push),
		.q_full       (q_full),
		.q_item       (q_wr_item)
	);

	sobmag_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.full    (q_full),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_item (q_rd_item)
	);

	sobmag_root u_root (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_item     (q_rd_item),
		.empty      (empty),
		.pop        (pop),
		.edge_res   (edge_res),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_done (frame_done)
	);

endmodule
